// ===== rtl/swsd_pkg.sv =====
// shared types and constants for the sliding window mean / deviation block
// word layouts, command codes, state encoding and fixed arithmetic widths
// no dependencies
package swsd_pkg;

   // field widths of the request and response words
   localparam int SAMPLE_W = 16;
   localparam int CHAN_W   = 3;
   localparam int COUNT_W  = 11;
   localparam int MEAN_W   = 16;
   localparam int ROOT_W   = 16;
   localparam int VAR_W    = 31;

   // running sum widths, both wrap
   localparam int SUM_W   = 26;
   localparam int SUMSQ_W = 41;
   localparam int SQ_W    = 2 * SAMPLE_W;

   // shared multiplier and variance divider widths
   localparam int MUL_W    = SUM_W;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int SQ_SPLIT = 21;
   localparam int VDEN_W   = 2 * COUNT_W;
   localparam int MAG_W    = SUM_W + 1;

   // square root accumulator
   localparam int ROOT_ACC_W = 32;
   localparam logic [ROOT_ACC_W-1:0] ROOT_BIT_FIRST = 32'h4000_0000;

   // window length after reset and variance ceiling
   localparam logic [COUNT_W-1:0] LEN_RESET = 11'd1000;
   localparam logic [VAR_W-1:0]   VAR_MAX   = 31'h4000_0000;

   // mean saturation bounds as magnitudes
   localparam logic [MAG_W-1:0] MEAN_POS_LIM = MAG_W'(2 ** (MEAN_W - 1) - 1);
   localparam logic [MAG_W-1:0] MEAN_NEG_LIM = MAG_W'(2 ** (MEAN_W - 1));

   typedef enum logic {
      CMD_PUSH  = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   typedef struct packed {
      logic                       cmd;
      logic [CHAN_W-1:0]          channel;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]        out_channel;
      logic [COUNT_W-1:0]       count;
      logic signed [MEAN_W-1:0] mean;
      logic [ROOT_W-1:0]        std_dev;
      logic [VAR_W-1:0]         variance;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MRD,
      S_META,
      S_SRD,
      S_OLD,
      S_SUMS,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_VST,
      S_VDIV,
      S_SQRT,
      S_EMIT
   } state_type;

endpackage

// ===== rtl/swsd_ram.sv =====
// generic simple dual port ram with registered read
// no dependencies
module swsd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              write_en,
   input  logic [ADDR_W-1:0] write_addr,
   input  logic [WIDTH-1:0]  write_data,
   input  logic [ADDR_W-1:0] read_addr,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      read_data_ff <= mem[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/swsd_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// no dependencies
module swsd_div #(
   parameter int NUM_W = 26,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);

   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

   logic             run_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;
   logic [DEN_W-1:0] rem_in;

   // one trial subtraction
   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      diff   = trial - {1'b0, den_ff};
      fits   = (trial >= {1'b0, den_ff});
      rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // dividend shifts out as quotient bits shift in
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

`ifndef SYNTHESIS
   a_start_clears_done : assert property (@(posedge clock) disable iff (reset)
      start |=> !done_ff)
      else $error("divider reports done straight after a start");

   a_run_excludes_done : assert property (@(posedge clock) disable iff (reset)
      run_ff |-> !done_ff)
      else $error("divider running and done at once");

   a_result_held : assert property (@(posedge clock) disable iff (reset)
      done_ff && !start |=> done_ff && $stable(quo_ff) && $stable(rem_ff))
      else $error("divider result changed without a new start");
`endif

endmodule

// ===== rtl/swsd_sqrt.sv =====
// floor square root, one result bit per cycle
// depends on swsd_pkg
module swsd_sqrt
   import swsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [VAR_W-1:0]  value,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic                  run_ff;
   logic                  done_ff;
   logic [ROOT_ACC_W-1:0] rest_ff;
   logic [ROOT_ACC_W-1:0] acc_ff;
   logic [ROOT_ACC_W-1:0] bit_ff;

   logic [ROOT_ACC_W-1:0] trial;
   logic                  fits;

   // trial subtraction for the current bit pair
   always_comb begin
      trial = acc_ff + bit_ff;
      fits  = (rest_ff >= trial);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
      end else if (run_ff && (bit_ff == ROOT_ACC_W'(1))) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   // digit by digit root
   always_ff @(posedge clock) begin
      if (start) begin
         rest_ff <= ROOT_ACC_W'(value);
         acc_ff  <= '0;
         bit_ff  <= ROOT_BIT_FIRST;
      end else if (run_ff) begin
         if (fits) begin
            rest_ff <= rest_ff - trial;
            acc_ff  <= (acc_ff >> 1) + bit_ff;
         end else begin
            acc_ff <= acc_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = acc_ff[ROOT_W-1:0];

endmodule

// ===== rtl/sliding_window_mean_std_variance.sv =====
// Sliding window mean, variance and standard deviation over several channels.
// Each push word appends a sample to its channel's ring in the sample memory,
// evicting the oldest one once the window holds window_length samples, and
// returns one response word with that channel's count, floor mean, floor
// variance and floor square root of the variance. Per channel pointers, counts
// and running sums live in a small state memory. A push passes through the
// memory reads, the sum update and four passes through the shared multiplier,
// then the bit serial variance division and the square root before its response
// word. A clear word or a push to a channel that does not exist returns all
// zeros. One word is processed at a time; the next is taken while the previous
// response still waits in the output register. window_length is only to be
// written while the block is idle; the block itself does not enforce this.
// Depends on swsd_pkg, swsd_ram, swsd_div, swsd_sqrt.
module sliding_window_mean_std_variance
   import swsd_pkg::*;
#(
   parameter int CHANNELS     = 7,
   parameter int WINDOW_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_word,
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata
);

   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int WP_W     = $clog2(WINDOW_DEPTH);
   localparam int CMP_W    = ((WP_W > COUNT_W) ? WP_W : COUNT_W) + 1;
   localparam int S_DEPTH  = CHANNELS * WINDOW_DEPTH;
   localparam int SADDR_W  = $clog2(S_DEPTH);
   localparam int META_W   = WP_W + COUNT_W + SUM_W + SUMSQ_W;
   localparam int LEN_CAP  = (WINDOW_DEPTH < (2 ** COUNT_W - 1)) ?
                             WINDOW_DEPTH : (2 ** COUNT_W - 1);
   localparam logic [COUNT_W-1:0] LEN_CAP_V  = COUNT_W'(LEN_CAP);
   localparam logic [4:0]         CHANNELS_V = 5'(CHANNELS);

   // control state
   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] len_ff;
   logic [CHANNELS-1:0] chan_valid_ff;
   logic               rsp_valid_ff;

   // item and datapath registers
   req_type             item_ff;
   logic [WP_W-1:0]     wp_ff;
   logic                full_ff;
   logic [COUNT_W-1:0]  fill_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUMSQ_W-1:0]  sumsq_ff;
   logic [SADDR_W-1:0]  saddr_ff;
   logic [SQ_W-1:0]     ssq_ff;
   logic signed [SAMPLE_W-1:0] old_ff;
   logic [SQ_W-1:0]     oldsq_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   nsq_ff;
   logic [PROD_W:0]     num_ff;
   logic signed [MEAN_W-1:0] mean_ff;
   logic [VAR_W-1:0]    var_ff;
   rsp_type             res_ff;
   rsp_type             rsp_word_ff;

   // fsm outputs
   logic meta_we;
   logic sample_we;
   logic mdiv_start;
   logic vdiv_start;
   logic sqrt_start;
   logic rsp_load;
   logic req_take;
   logic item_short;

   // combinational datapath
   logic [CH_IDX_W-1:0] ch_idx;
   logic [COUNT_W-1:0]  len_eff;
   logic [META_W-1:0]   meta_rdata;
   logic [META_W-1:0]   meta_rd;
   logic [META_W-1:0]   meta_wdata;
   logic [WP_W-1:0]     wp_rd;
   logic [COUNT_W-1:0]  fill_rd;
   logic [SUM_W-1:0]    sum_rd;
   logic [SUMSQ_W-1:0]  sumsq_rd;
   logic [WP_W-1:0]     wp_adj;
   logic                full_now;
   logic [CMP_W-1:0]    wp_inc_x;
   logic [WP_W-1:0]     wp_next;
   logic [SUM_W-1:0]    sum_next;
   logic [SUMSQ_W-1:0]  sumsq_next;
   logic [SAMPLE_W-1:0] sample_rdata;
   logic signed [SAMPLE_W-1:0] old_val;
   logic signed [SQ_W-1:0] ssq_full;
   logic signed [SQ_W-1:0] oldsq_full;
   logic [MUL_W-1:0]    mul_a;
   logic [MUL_W-1:0]    mul_b;
   logic [PROD_W-1:0]   prod_in;
   logic                sum_neg;
   logic [SUM_W-1:0]    sum_abs;
   logic [SUM_W-1:0]    mdiv_quo;
   logic [COUNT_W-1:0]  mdiv_rem;
   logic                mdiv_done;
   logic [PROD_W-1:0]   vdiv_quo;
   logic [VDEN_W-1:0]   vdiv_rem;
   logic                vdiv_done;
   logic [PROD_W-1:0]   vdiv_num;
   logic [MAG_W-1:0]    mean_mag;
   logic [MAG_W-1:0]    mean_neg_mag;
   logic signed [MEAN_W-1:0] mean_val;
   logic [VAR_W-1:0]    var_sat;
   logic                sqrt_done;
   logic [ROOT_W-1:0]   sqrt_root;

   assign ch_idx     = CH_IDX_W'(item_ff.channel);
   assign item_short = (req_word.cmd == CMD_CLEAR) ||
                       (5'(req_word.channel) >= CHANNELS_V);
   assign req_take   = req_valid && !req_stall;

   // effective window length
   always_comb begin
      if (len_ff == '0) begin
         len_eff = COUNT_W'(1);
      end else if (len_ff > LEN_CAP_V) begin
         len_eff = LEN_CAP_V;
      end else begin
         len_eff = len_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = item_short ? S_EMIT : S_MRD;
            end
         end
         S_MRD:  state_in = S_META;
         S_META: state_in = S_SRD;
         S_SRD:  state_in = S_OLD;
         S_OLD:  state_in = S_SUMS;
         S_SUMS: state_in = S_MUL0;
         S_MUL0: state_in = S_MUL1;
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_MUL3;
         S_MUL3: state_in = S_VST;
         S_VST:  state_in = S_VDIV;
         S_VDIV: begin
            if (vdiv_done) begin
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sqrt_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_stall  = 1'b1;
      meta_we    = 1'b0;
      sample_we  = 1'b0;
      mdiv_start = 1'b0;
      vdiv_start = 1'b0;
      sqrt_start = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE: req_stall  = 1'b0;
         S_OLD:  sample_we  = 1'b1;
         S_SUMS: meta_we    = 1'b1;
         S_MUL0: mdiv_start = 1'b1;
         S_VST:  vdiv_start = 1'b1;
         S_VDIV: sqrt_start = vdiv_done;
         S_EMIT: rsp_load   = !rsp_valid_ff || !rsp_stall;
         default: begin
         end
      endcase
   end

   // channel state unpacking, an entry not written since clear reads as zero
   always_comb begin
      meta_rd  = chan_valid_ff[ch_idx] ? meta_rdata : '0;
      wp_rd    = meta_rd[META_W-1 -: WP_W];
      fill_rd  = meta_rd[SUMSQ_W + SUM_W +: COUNT_W];
      sum_rd   = meta_rd[SUMSQ_W +: SUM_W];
      sumsq_rd = meta_rd[SUMSQ_W-1:0];
      wp_adj   = (CMP_W'(wp_rd) >= CMP_W'(len_eff)) ? '0 : wp_rd;
      full_now = (fill_rd >= len_eff);
   end

   // ring pointer advance and running sums
   always_comb begin
      wp_inc_x   = CMP_W'(wp_ff) + CMP_W'(1);
      wp_next    = (wp_inc_x >= CMP_W'(len_eff)) ? '0 : WP_W'(wp_inc_x);
      sum_next   = sum_ff - SUM_W'(old_ff) + SUM_W'(item_ff.sample);
      sumsq_next = sumsq_ff - SUMSQ_W'(oldsq_ff) + SUMSQ_W'(ssq_ff);
      meta_wdata = {wp_next, fill_ff, sum_next, sumsq_next};
   end

   // squares of the new and the evicted sample
   assign old_val    = full_ff ? $signed(sample_rdata) : '0;
   assign ssq_full   = item_ff.sample * item_ff.sample;
   assign oldsq_full = old_val * old_val;

   // shared multiplier operand selection
   assign sum_neg = sum_ff[SUM_W-1];
   assign sum_abs = sum_neg ? (~sum_ff + SUM_W'(1)) : sum_ff;

   always_comb begin
      mul_a = MUL_W'(fill_ff);
      mul_b = MUL_W'(fill_ff);
      case (state_ff)
         S_MUL0: mul_b = MUL_W'(sumsq_ff[SQ_SPLIT-1:0]);
         S_MUL1: mul_b = MUL_W'(sumsq_ff[SUMSQ_W-1:SQ_SPLIT]);
         S_MUL2: begin
            mul_a = sum_abs;
            mul_b = sum_abs;
         end
         default: begin
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // floor mean with saturation
   always_comb begin
      mean_mag     = MAG_W'(mdiv_quo) + MAG_W'(sum_neg && (mdiv_rem != '0));
      mean_neg_mag = ~mean_mag + MAG_W'(1);
      if (!sum_neg && (mean_mag > MEAN_POS_LIM)) begin
         mean_val = {1'b0, {(MEAN_W - 1){1'b1}}};
      end else if (sum_neg && (mean_mag > MEAN_NEG_LIM)) begin
         mean_val = {1'b1, {(MEAN_W - 1){1'b0}}};
      end else if (sum_neg) begin
         mean_val = mean_neg_mag[MEAN_W-1:0];
      end else begin
         mean_val = mean_mag[MEAN_W-1:0];
      end
   end

   // variance numerator clamp and ceiling
   assign vdiv_num = num_ff[PROD_W] ? '0 : num_ff[PROD_W-1:0];
   assign var_sat  = (vdiv_quo > PROD_W'(VAR_MAX)) ? VAR_MAX : vdiv_quo[VAR_W-1:0];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         len_ff        <= LEN_RESET;
         chan_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            len_ff <= csr_wdata;
         end
         if (req_take && (req_word.cmd == CMD_CLEAR)) begin
            chan_valid_ff <= '0;
         end else if (meta_we) begin
            chan_valid_ff[ch_idx] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_ff <= req_word;
               res_ff  <= '0;
            end
         end
         S_META: begin
            wp_ff    <= wp_adj;
            full_ff  <= full_now;
            fill_ff  <= full_now ? len_eff : fill_rd + COUNT_W'(1);
            sum_ff   <= sum_rd;
            sumsq_ff <= sumsq_rd;
            saddr_ff <= SADDR_W'(ch_idx) * SADDR_W'(WINDOW_DEPTH) + SADDR_W'(wp_adj);
            ssq_ff   <= SQ_W'(ssq_full);
         end
         S_OLD: begin
            old_ff   <= old_val;
            oldsq_ff <= SQ_W'(oldsq_full);
         end
         S_SUMS: begin
            sum_ff   <= sum_next;
            sumsq_ff <= sumsq_next;
         end
         S_MUL0: prod_ff <= prod_in;
         S_MUL1: begin
            nsq_ff  <= prod_ff;
            prod_ff <= prod_in;
         end
         S_MUL2: begin
            nsq_ff  <= nsq_ff + (prod_ff << SQ_SPLIT);
            prod_ff <= prod_in;
         end
         S_MUL3: begin
            num_ff  <= {1'b0, nsq_ff} - {1'b0, prod_ff};
            prod_ff <= prod_in;
         end
         S_VDIV: begin
            if (vdiv_done) begin
               var_ff  <= var_sat;
               mean_ff <= mean_val;
            end
         end
         S_SQRT: begin
            if (sqrt_done) begin
               res_ff.out_channel <= item_ff.channel;
               res_ff.count       <= fill_ff;
               res_ff.mean        <= mean_ff;
               res_ff.std_dev     <= sqrt_root;
               res_ff.variance    <= var_ff;
            end
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_word_ff <= res_ff;
      end
   end

   // per channel pointer, count and sums
   swsd_ram #(
      .WIDTH (META_W),
      .DEPTH (CHANNELS)
   ) u_meta_ram (
      .clock      (clock),
      .write_en   (meta_we),
      .write_addr (ch_idx),
      .write_data (meta_wdata),
      .read_addr  (ch_idx),
      .read_data  (meta_rdata)
   );

   // sample rings of all channels
   swsd_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (S_DEPTH)
   ) u_sample_ram (
      .clock      (clock),
      .write_en   (sample_we),
      .write_addr (saddr_ff),
      .write_data (item_ff.sample),
      .read_addr  (saddr_ff),
      .read_data  (sample_rdata)
   );

   // mean divider
   swsd_div #(
      .NUM_W (SUM_W),
      .DEN_W (COUNT_W)
   ) u_mean_div (
      .clock     (clock),
      .reset     (reset),
      .start     (mdiv_start),
      .dividend  (sum_abs),
      .divisor   (fill_ff),
      .done      (mdiv_done),
      .quotient  (mdiv_quo),
      .remainder (mdiv_rem)
   );

   // variance divider
   swsd_div #(
      .NUM_W (PROD_W),
      .DEN_W (VDEN_W)
   ) u_var_div (
      .clock     (clock),
      .reset     (reset),
      .start     (vdiv_start),
      .dividend  (vdiv_num),
      .divisor   (prod_ff[VDEN_W-1:0]),
      .done      (vdiv_done),
      .quotient  (vdiv_quo),
      .remainder (vdiv_rem)
   );

   // standard deviation
   swsd_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (var_sat),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   a_count_in_window : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL0 |-> (fill_ff != '0) && (fill_ff <= len_eff))
      else $error("window count outside one to window length");

   a_mean_before_var : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VDIV) && vdiv_done |-> mdiv_done)
      else $error("mean division still running when variance is done");

   a_rsp_loaded : assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("response word not presented after load");

   a_remainder_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VDIV) && vdiv_done |-> vdiv_rem < prod_ff[VDEN_W-1:0])
      else $error("variance remainder not below divisor");
`endif

endmodule

// ===== bench/swsd_stats_checker.sv =====
// watches the request, response and register ports of the sliding window block,
// predicts each response word from its own copy of the windows and compares them
// depends on swsd_pkg
module swsd_stats_checker
   import swsd_pkg::*;
#(
   parameter int CHANNELS     = 7,
   parameter int WINDOW_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  req_type            req_word,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  rsp_type            rsp_word,
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata,
   output int                 outstanding,
   output logic [COUNT_W-1:0] safe_length,
   output int                 fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PTR_W = $clog2(WINDOW_DEPTH);

   // own copy of the windows and their running sums
   logic [SAMPLE_W-1:0] window_ring [CHANNELS][WINDOW_DEPTH];
   bit                  ring_seen   [CHANNELS][WINDOW_DEPTH];
   int unsigned         ring_reach  [CHANNELS];
   logic [PTR_W-1:0]    ring_ptr    [CHANNELS];
   logic [COUNT_W-1:0]  ring_fill   [CHANNELS];
   logic [SUM_W-1:0]    ring_sum    [CHANNELS];
   logic [SUMSQ_W-1:0]  ring_sumsq  [CHANNELS];
   logic [COUNT_W-1:0]  ring_len;

   // statistics words still owed by the block, oldest first
   rsp_type stats_due [$];

   initial fail_count = 0;

   // apply one request word to the windows and work out the statistics word
   function automatic rsp_type stats_after(input req_type w);
      rsp_type                    r;
      int unsigned                ch, len, wp;
      logic signed [SUM_W-1:0]    sum_s;
      longint                     s_val, e_val, sq_tmp, n, total, sqv, q, num, v, root, trial;
      r = '0;
      if (w.cmd == CMD_CLEAR) begin
         for (int c = 0; c < CHANNELS; c++) begin
            ring_ptr[c]   = '0;
            ring_fill[c]  = '0;
            ring_sum[c]   = '0;
            ring_sumsq[c] = '0;
         end
         return r;
      end
      ch = w.channel;
      if (ch >= CHANNELS)
         return r;

      // length register clamped to what the store holds
      len = (ring_len == 0) ? 1 : ((ring_len > WINDOW_DEPTH) ? WINDOW_DEPTH : ring_len);
      wp = ring_ptr[ch];
      if (wp >= len)
         wp = 0;

      // full window: drop the oldest sample from both sums
      if (ring_fill[ch] >= len) begin
         e_val = $signed(window_ring[ch][wp]);
         sq_tmp = e_val * e_val;
         ring_sum[ch]   = ring_sum[ch] - e_val[SUM_W-1:0];
         ring_sumsq[ch] = ring_sumsq[ch] - sq_tmp[SUMSQ_W-1:0];
         ring_fill[ch]  = len[COUNT_W-1:0];
      end else begin
         ring_fill[ch] = ring_fill[ch] + 1'b1;
      end

      // store the new sample and note how far the ring has been written
      window_ring[ch][wp] = w.sample;
      ring_seen[ch][wp] = 1'b1;
      while (ring_reach[ch] < WINDOW_DEPTH && ring_seen[ch][ring_reach[ch]])
         ring_reach[ch]++;
      s_val = w.sample;
      sq_tmp = s_val * s_val;
      ring_sum[ch]   = ring_sum[ch] + s_val[SUM_W-1:0];
      ring_sumsq[ch] = ring_sumsq[ch] + sq_tmp[SUMSQ_W-1:0];
      ring_ptr[ch] = (wp + 1 >= len) ? '0 : PTR_W'(wp + 1);

      // floor mean, saturated
      n = ring_fill[ch];
      sum_s = ring_sum[ch];
      total = sum_s;
      sqv = ring_sumsq[ch];
      q = total / n;
      if ((total % n) != 0 && total < 0)
         q = q - 1;
      if (q > 32767)
         q = 32767;
      if (q < -32768)
         q = -32768;

      // floor variance, clipped at zero and at the ceiling
      num = n * sqv - total * total;
      v = (num < 0) ? 0 : num / (n * n);
      if (v > longint'(VAR_MAX))
         v = VAR_MAX;

      // floor square root, one result bit at a time from the top
      root = 0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root + (longint'(1) << b);
         if (trial * trial <= v)
            root = trial;
      end

      r.out_channel = w.channel;
      r.count       = n[COUNT_W-1:0];
      r.mean        = q[MEAN_W-1:0];
      r.std_dev     = root[ROOT_W-1:0];
      r.variance    = v[VAR_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string why, input rsp_type want, input rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch (%s): expected ch %0d count %0d mean %0d std %0d var %0d, got ch %0d count %0d mean %0d std %0d var %0d",
                  why, want.out_channel, want.count, want.mean, want.std_dev, want.variance,
                  got.out_channel, got.count, got.mean, got.std_dev, got.variance);
   endtask

   always @(posedge clock) begin
      rsp_type     want;
      int unsigned lim;
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            ring_ptr[c]   = '0;
            ring_fill[c]  = '0;
            ring_sum[c]   = '0;
            ring_sumsq[c] = '0;
         end
         ring_len = LEN_RESET;
         stats_due.delete();
      end else begin
         // response word against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (stats_due.size() == 0) begin
               report_mismatch("word with nothing expected", '0, rsp_word);
            end else begin
               want = stats_due.pop_front();
               if (rsp_word.out_channel !== want.out_channel || rsp_word.count !== want.count ||
                   rsp_word.mean !== want.mean || rsp_word.std_dev !== want.std_dev ||
                   rsp_word.variance !== want.variance)
                  report_mismatch("field differs", want, rsp_word);
            end
         end
         if (csr_we)
            ring_len = csr_wdata;
         if (req_valid && !req_stall)
            stats_due.push_back(stats_after(req_word));
      end

      // longest window that can be set without a clear and never evict an unwritten slot
      lim = WINDOW_DEPTH;
      for (int c = 0; c < CHANNELS; c++) begin
         if (ring_fill[c] != 0 && ring_reach[c] < lim)
            lim = ring_reach[c];
      end
      safe_length <= lim[COUNT_W-1:0];
      outstanding <= stats_due.size();
   end

endmodule

// ===== bench/sliding_window_mean_std_variance_test.sv =====
// top of the sliding window statistics test: clock, reset, stimulus and verdict
// instantiates sliding_window_mean_std_variance and swsd_stats_checker, uses swsd_pkg
module sliding_window_mean_std_variance_test;
   import swsd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNELS     = 7;
   localparam int WINDOW_DEPTH = 1024;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_word  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_word;
   logic               csr_we    = 1'b0;
   logic [COUNT_W-1:0] csr_wdata = '0;

   int                 outstanding;
   logic [COUNT_W-1:0] safe_length;
   int                 fail_count;

   // idle mode of each side, toggled to give stretches without gaps
   bit                 req_calm  = 1'b0;
   logic               rsp_calm  = 1'b0;
   int unsigned        rsp_wait  = 0;

   sliding_window_mean_std_variance #(
      .CHANNELS     (CHANNELS),
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   swsd_stats_checker #(
      .CHANNELS     (CHANNELS),
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_chk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .safe_length (safe_length),
      .fail_count  (fail_count)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // response side: a fresh stall count per word, counted while the word is offered
   always @(posedge clock) begin
      int unsigned hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         hold = rsp_calm ? 0 : $urandom_range(0, 13);
         rsp_wait  <= hold;
         rsp_stall <= (hold != 0);
      end else if (rsp_valid && rsp_wait != 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_stall <= (rsp_wait > 1);
      end
   end

   function automatic req_type word_of(input cmd_type c, input logic [CHAN_W-1:0] ch,
                                       input logic signed [SAMPLE_W-1:0] s);
      req_type w;
      w.cmd     = c;
      w.channel = ch;
      w.sample  = s;
      return w;
   endfunction

   // offer one word after a random gap and hold it until taken
   task automatic send_word(input req_type w);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // stop sending until every predicted word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_length(input logic [COUNT_W-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // one setting of the window length followed by random words
   task automatic run_phase(input logic [COUNT_W-1:0] len_value, input int items,
                            input int unsigned span, input bit noisy, input bit keep_windows);
      int unsigned eff, pick;
      logic signed [SAMPLE_W-1:0] s;
      req_type w;
      eff = (len_value == 0) ? 1 : ((len_value > WINDOW_DEPTH) ? WINDOW_DEPTH : len_value);
      wait_drained();
      // a longer window is only kept without a clear when every slot it reaches was written
      if (!keep_windows || safe_length < eff) begin
         send_word(word_of(CMD_CLEAR, 3'($urandom), 16'($urandom)));
         wait_drained();
      end
      write_length(len_value);
      for (int i = 0; i < items; i++) begin
         case ($urandom_range(0, 7))
            0:       s = 16'sh8000;
            1:       s = 16'sh7fff;
            2, 3:    s = 16'($urandom_range(0, 64) - 32);
            default: s = 16'($urandom);
         endcase
         pick = $urandom_range(0, 99);
         if (noisy && pick < 3)
            w = word_of(CMD_CLEAR, 3'($urandom), 16'($urandom));
         else if (noisy && pick < 7)
            w = word_of(CMD_PUSH, 3'd7, s);
         else
            w = word_of(CMD_PUSH, 3'($urandom_range(0, span)), s);
         if ($urandom_range(0, 39) == 0)
            wait_drained();
         if ($urandom_range(0, 24) == 0)
            req_calm = !req_calm;
         if ($urandom_range(0, 24) == 0)
            rsp_calm <= !rsp_calm;
         send_word(w);
      end
   endtask

   // run limit
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic [COUNT_W-1:0] lengths [11];
      lengths = '{11'd1, 11'd2, 11'd3, 11'd4, 11'd5, 11'd8, 11'd13, 11'd32, 11'd0, 11'd1024,
                  11'd1500};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset length: extremes, negative floor mean, missing channel, clear
      send_word(word_of(CMD_PUSH, 3'd0, 16'sh7fff));
      send_word(word_of(CMD_PUSH, 3'd0, 16'sh8000));
      send_word(word_of(CMD_PUSH, 3'd0, 16'sd0));
      send_word(word_of(CMD_PUSH, 3'd0, -16'sd1));
      send_word(word_of(CMD_PUSH, 3'd1, 16'sd1));
      send_word(word_of(CMD_PUSH, 3'd6, 16'sh8000));
      send_word(word_of(CMD_PUSH, 3'd6, 16'sh7fff));
      send_word(word_of(CMD_PUSH, 3'd7, 16'sh5a5a));
      send_word(word_of(CMD_CLEAR, 3'd5, 16'shffff));
      send_word(word_of(CMD_PUSH, 3'd6, -16'sd1));

      // zero length acts as a single sample window
      wait_drained();
      send_word(word_of(CMD_CLEAR, 3'd0, 16'sd0));
      wait_drained();
      write_length(11'd0);
      send_word(word_of(CMD_PUSH, 3'd2, 16'sd100));
      send_word(word_of(CMD_PUSH, 3'd2, -16'sd100));
      send_word(word_of(CMD_PUSH, 3'd2, 16'sd7));

      // widest spread with eviction, then shorter and longer windows without a clear
      wait_drained();
      send_word(word_of(CMD_CLEAR, 3'd3, 16'sd0));
      wait_drained();
      write_length(11'd3);
      send_word(word_of(CMD_PUSH, 3'd3, 16'sh8000));
      send_word(word_of(CMD_PUSH, 3'd3, 16'sh7fff));
      send_word(word_of(CMD_PUSH, 3'd3, 16'sh8000));
      send_word(word_of(CMD_PUSH, 3'd3, 16'sh7fff));
      wait_drained();
      write_length(11'd2);
      send_word(word_of(CMD_PUSH, 3'd3, 16'sd5));
      send_word(word_of(CMD_PUSH, 3'd3, -16'sd9));
      wait_drained();
      write_length(11'd3);
      send_word(word_of(CMD_PUSH, 3'd3, 16'sh7fff));
      send_word(word_of(CMD_PUSH, 3'd3, -16'sd3));

      // oversized length acts as the full store: fill one ring and wrap it
      run_phase(11'd2047, 1030, 0, 1'b0, 1'b0);

      // windows from the length list, with and without a clear between settings
      for (int p = 0; p < 12; p++)
         run_phase(lengths[$urandom_range(0, 10)], 45, $urandom_range(1, 6), 1'b1,
                   $urandom_range(0, 2) == 0);

      wait_drained();
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
